@@ design/signed_integer_to_ascii_text_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to ASCII text unit.
// These macros wrap clocked, reset-gated assertions.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_ASCII_TEXT_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_ASCII_TEXT_UNIT_DEFINES_SVH

// This macro asserts that the consequent holds in the same cycle.
`define SITA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sita assertion failed");

// This macro asserts that the consequent holds in the next cycle.
`define SITA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sita assertion failed");

`endif

@@ design/sita_pkg.sv @@
// ----------------------------------------------------------------------------
// sita_pkg
// This package holds the shared types and constants of the text unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sita_pkg;
	localparam int MaxChars  = 11;
	localparam int DecDigits = 10;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChX     = 8'h78;
	localparam logic [7:0] ChA     = 8'h61;

	// This struct is the payload of one conversion stage.
	typedef struct packed {
		logic        neg;
		logic        hex;
		logic [31:0] mag;
		logic [31:0] work;
		logic [39:0] bcd;
	} dd_t;

	// This struct is the formatted text of one item.
	typedef struct packed {
		logic [MaxChars-1:0][7:0] text;
		logic [3:0]               len;
	} fmt_t;

	// This function maps a digit value to its lower-case ASCII code.
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = ChZero + {4'd0, d};
		end else begin
			c = ChA + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction
endpackage

@@ design/sita_dabble.sv @@
// ----------------------------------------------------------------------------
// sita_dabble
// One pipeline stage of the binary to BCD converter: eight shift-add-three steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sita_dabble (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sita_pkg::dd_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sita_pkg::dd_t out_data
);
	import sita_pkg::*;

	logic stage_valid_s1;
	dd_t  stage_data_s1;
	dd_t  next_data;

	assign in_ready  = !stage_valid_s1 || out_ready;
	assign out_valid = stage_valid_s1;
	assign out_data  = stage_data_s1;

	// Eight bits of the working magnitude are shifted into the BCD digits.
	always_comb begin
		next_data = in_data;
		for (int s = 0; s < 8; s++) begin
			for (int d = 0; d < DecDigits; d++) begin
				if (next_data.bcd[d*4 +: 4] >= 4'd5) begin
					next_data.bcd[d*4 +: 4] = next_data.bcd[d*4 +: 4] + 4'd3;
				end
			end
			next_data.bcd  = {next_data.bcd[38:0], next_data.work[31]};
			next_data.work = {next_data.work[30:0], 1'b0};
		end
	end

	// The valid bit advances whenever this stage can accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			stage_valid_s1 <= in_valid;
		end
	end

	// The payload is loaded together with its valid bit.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			stage_data_s1 <= next_data;
		end
	end
endmodule

@@ design/sita_format.sv @@
// ----------------------------------------------------------------------------
// sita_format
// Builds the character string of one item from its sign, radix and digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sita_format (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sita_pkg::dd_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sita_pkg::fmt_t out_data
);
	import sita_pkg::*;

	logic                      fmt_valid_s1;
	fmt_t                      fmt_data_s1;
	fmt_t                      next_fmt;
	logic [DecDigits-1:0][3:0] digits;
	logic [3:0]                nd;
	logic [3:0]                pre;
	logic [4:0]                k;

	assign in_ready  = !fmt_valid_s1 || out_ready;
	assign out_valid = fmt_valid_s1;
	assign out_data  = fmt_data_s1;

	// Digits come from the BCD word in decimal and from the nibbles in hex.
	always_comb begin
		for (int d = 0; d < DecDigits; d++) begin
			if (in_data.hex) begin
				digits[d] = (d < 8) ? in_data.mag[(d%8)*4 +: 4] : 4'd0;
			end else begin
				digits[d] = in_data.bcd[d*4 +: 4];
			end
		end
	end

	// The digit count skips leading zeros but keeps at least one digit.
	always_comb begin
		nd = 4'd1;
		for (int d = 0; d < DecDigits; d++) begin
			if (digits[d] != 4'd0) begin
				nd = 4'(d + 1);
			end
		end
		pre = {3'd0, in_data.neg} + (in_data.hex ? 4'd2 : 4'd0);
	end

	// Each text slot takes a prefix character or the matching digit.
	always_comb begin
		next_fmt.len = pre + nd;
		k = 5'd0;
		for (int j = 0; j < MaxChars; j++) begin
			k = {1'b0, nd} + {1'b0, pre} - 5'd1 - 5'(j);
			if (4'(j) < pre) begin
				if (in_data.neg && j == 0) begin
					next_fmt.text[j] = ChMinus;
				end else if (4'(j) == pre - 4'd2) begin
					next_fmt.text[j] = ChZero;
				end else begin
					next_fmt.text[j] = ChX;
				end
			end else if (k < 5'd10) begin
				next_fmt.text[j] = digit_char(digits[k[3:0]]);
			end else begin
				next_fmt.text[j] = 8'd0;
			end
		end
	end

	// The valid bit advances whenever this stage can accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			fmt_valid_s1 <= in_valid;
		end
	end

	// The text is loaded together with its valid bit.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			fmt_data_s1 <= next_fmt;
		end
	end
endmodule

@@ design/signed_integer_to_ascii_text_unit.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_text_unit
// Converts a signed 32-bit value to decimal or 0x-prefixed hex ASCII text.
//
// Channel  Dir  tdata                          tuser / tlast
// s_*      in   value[31:0]                    tuser: opcode (1 = hex)
// m_*      out  character[7:0], position[11:8] tlast: final character
//
// An item passes an input register, four BCD stages and a format stage
// before the output register shows its first character.
// The output register sends one character per cycle while m_tready is high;
// an item has one to eleven characters, and the next text loads as its last
// beat leaves. Reset clears all valid bits; a full stage holds while the next is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_integer_to_ascii_text_unit_defines.svh"
module signed_integer_to_ascii_text_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // character[7:0], position[11:8], zeros[15:12]
	output logic        m_tlast
);
	import sita_pkg::*;

	logic                     in_valid_s1;
	dd_t                      in_data_s1;
	logic [4:0]               dd_valid;
	logic [4:0]               dd_ready;
	dd_t  [4:0]               dd_data;
	logic                     fmt_valid;
	fmt_t                     fmt_data;
	logic                     load;
	logic                     busy_q;
	logic [MaxChars-1:0][7:0] text_q;
	logic [3:0]               len_q;
	logic [3:0]               pos_q;
	logic                     is_last;
	logic                     fire;

	// The input register takes the sign and magnitude.
	assign s_tready = !in_valid_s1 || dd_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s1.neg  <= s_tdata[31];
			in_data_s1.hex  <= s_tuser;
			in_data_s1.mag  <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
			in_data_s1.work <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
			in_data_s1.bcd  <= 40'd0;
		end
	end

	assign dd_valid[0] = in_valid_s1;
	assign dd_data[0]  = in_data_s1;

	// Four BCD stages each take eight magnitude bits.
	for (genvar g = 0; g < 4; g++) begin : g_dabble
		sita_dabble u_dabble (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dd_valid[g]),
			.in_ready  (dd_ready[g]),
			.in_data   (dd_data[g]),
			.out_valid (dd_valid[g+1]),
			.out_ready (dd_ready[g+1]),
			.out_data  (dd_data[g+1])
		);
	end

	sita_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dd_valid[4]),
		.in_ready  (dd_ready[4]),
		.in_data   (dd_data[4]),
		.out_valid (fmt_valid),
		.out_ready (load),
		.out_data  (fmt_data)
	);

	// The output register walks through the text one beat at a time.
	assign is_last = (pos_q == len_q - 4'd1);
	assign fire    = busy_q && m_tready;
	assign load    = !busy_q || (fire && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 4'd0;
		end else if (load) begin
			busy_q <= fmt_valid;
			pos_q  <= 4'd0;
		end else if (fire) begin
			pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && fmt_valid) begin
			text_q <= fmt_data.text;
			len_q  <= fmt_data.len;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {4'd0, pos_q, text_q[pos_q]};
	assign m_tlast  = is_last;

	// The position stays inside the text and steps by one per beat.
	`SITA_ASSERT_NOW(a_pos_in_text, busy_q, pos_q < len_q)
	`SITA_ASSERT_NOW(a_len_range, busy_q, len_q >= 4'd1 && len_q <= 4'd11)
	`SITA_ASSERT_NEXT(a_pos_step, fire && !is_last, pos_q == $past(pos_q) + 4'd1)
endmodule
